// ===== hdl/bfd_pkg.sv =====
// ----------------------------------------------------------------------------
// bfd_pkg
// Shared constants and types of the box filter downsampler: register map,
// field widths, reset values and the control flags that travel with an item.
// ----------------------------------------------------------------------------
package bfd_pkg;

   // Pixel channel width
   localparam int PIX_W = 8;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;
   localparam int FACTOR_W   = 4;
   localparam int DIM_W      = 12;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FACTOR = 2'd0,
      CSR_WIDTH  = 2'd1,
      CSR_HEIGHT = 2'd2
   } bfd_csr_type;

   // Register reset values
   localparam logic [FACTOR_W-1:0] RST_FACTOR = 4'd1;
   localparam logic [DIM_W-1:0]    RST_WIDTH  = 12'd640;
   localparam logic [DIM_W-1:0]    RST_HEIGHT = 12'd480;

   // Default sizing of the top level
   localparam int DEF_MAX_WIDTH  = 2048;
   localparam int DEF_MAX_HEIGHT = 2048;
   localparam int DEF_MAX_FACTOR = 8;

   // Per-item flags from the position sequencer to the accumulator
   typedef struct packed {
      logic active;  // pixel lies inside a whole block
      logic first;   // top-left pixel of its block
      logic emit;    // bottom-right pixel of an active block
      logic last;    // block is the last one of the frame
   } bfd_ctl_type;

endpackage

// ===== hdl/bfd_axis.sv =====
// ----------------------------------------------------------------------------
// bfd_axis
// One position counter of the frame (column or row): tracks the position,
// the offset inside the current block, the block index and the block base,
// and tells whether the current block is whole and whether it is the last.
// ----------------------------------------------------------------------------
module bfd_axis #(
   parameter int POS_W = 11,
   parameter int DIM_W = 12,
   parameter int CW    = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             restart,
   input  logic             step,
   input  logic [CW-1:0]    s,
   input  logic [DIM_W-1:0] dim,
   output logic [POS_W-1:0] idx,
   output logic             sub_first,
   output logic             sub_last,
   output logic             blk_act,
   output logic             blk_last,
   output logic             wrap
);

   localparam int LW = ((DIM_W > CW) ? DIM_W : CW) + 2;

   logic [POS_W-1:0] pos_ff;
   logic [POS_W-1:0] base_ff;
   logic [POS_W-1:0] idx_ff;
   logic [CW-1:0]    sub_ff;
   logic [LW-1:0]    blk_end;

   // Decode the current position
   always_comb begin
      blk_end   = LW'(base_ff) + LW'(s);
      blk_act   = (blk_end <= LW'(dim));
      blk_last  = ((blk_end + LW'(s)) > LW'(dim));
      sub_first = (sub_ff == '0);
      sub_last  = (sub_ff == s - CW'(1));
      wrap      = (DIM_W'(pos_ff) == dim - DIM_W'(1));
      idx       = idx_ff;
   end

   // Advance by one pixel, wrap at the end of the line or frame
   always_ff @(posedge clock) begin
      if (reset || restart) begin
         pos_ff  <= '0;
         base_ff <= '0;
         idx_ff  <= '0;
         sub_ff  <= '0;
      end else if (step) begin
         if (wrap) begin
            pos_ff  <= '0;
            base_ff <= '0;
            idx_ff  <= '0;
            sub_ff  <= '0;
         end else begin
            pos_ff <= pos_ff + POS_W'(1);
            if (sub_last) begin
               sub_ff  <= '0;
               idx_ff  <= idx_ff + POS_W'(1);
               base_ff <= pos_ff + POS_W'(1);
            end else begin
               sub_ff <= sub_ff + CW'(1);
            end
         end
      end
   end

endmodule

// ===== hdl/bfd_pos.sv =====
// ----------------------------------------------------------------------------
// bfd_pos
// Position sequencer: column and row counters that give, for the pixel now
// offered, its block column (the accumulator address) and its block flags.
// ----------------------------------------------------------------------------
module bfd_pos #(
   parameter int CPW = 11,
   parameter int RPW = 11,
   parameter int WW  = 12,
   parameter int HW  = 12,
   parameter int CW  = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                restart,
   input  logic                accept,
   input  logic [CW-1:0]       s,
   input  logic [WW-1:0]       w,
   input  logic [HW-1:0]       h,
   output logic [CPW-1:0]      addr,
   output bfd_pkg::bfd_ctl_type ctl
);
   import bfd_pkg::*;

   logic col_sub_first;
   logic col_sub_last;
   logic col_act;
   logic col_last;
   logic col_wrap;
   logic row_sub_first;
   logic row_sub_last;
   logic row_act;
   logic row_last;
   logic row_wrap;

   bfd_axis #(
      .POS_W (CPW),
      .DIM_W (WW),
      .CW    (CW)
   ) u_col (
      .clock     (clock),
      .reset     (reset),
      .restart   (restart),
      .step      (accept),
      .s         (s),
      .dim       (w),
      .idx       (addr),
      .sub_first (col_sub_first),
      .sub_last  (col_sub_last),
      .blk_act   (col_act),
      .blk_last  (col_last),
      .wrap      (col_wrap)
   );

   // Rows advance when a line wraps
   bfd_axis #(
      .POS_W (RPW),
      .DIM_W (HW),
      .CW    (CW)
   ) u_row (
      .clock     (clock),
      .reset     (reset),
      .restart   (restart),
      .step      (accept && col_wrap),
      .s         (s),
      .dim       (h),
      .idx       (),
      .sub_first (row_sub_first),
      .sub_last  (row_sub_last),
      .blk_act   (row_act),
      .blk_last  (row_last),
      .wrap      (row_wrap)
   );

   // Combine both axes into the item flags
   always_comb begin
      ctl.active = col_act && row_act;
      ctl.first  = col_sub_first && row_sub_first;
      ctl.emit   = col_act && row_act && col_sub_last && row_sub_last;
      ctl.last   = col_last && row_last && !(row_wrap && !col_wrap && 1'b0);
   end

endmodule

// ===== hdl/bfd_acc.sv =====
// ----------------------------------------------------------------------------
// bfd_acc
// Block sum accumulator: one memory entry per block column holding the three
// channel sums. Read on accept, then add the pixel and write back.
// The last write is forwarded to a read issued on the same edge.
// ----------------------------------------------------------------------------
module bfd_acc #(
   parameter int AW    = 11,
   parameter int DEPTH = 2048,
   parameter int SUM_W = 14
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  logic                     accept,
   input  logic [AW-1:0]            addr,
   input  bfd_pkg::bfd_ctl_type     ctl,
   input  logic [3*bfd_pkg::PIX_W-1:0] pix,
   output logic                     sum_valid,
   output logic [3*SUM_W-1:0]       sum,
   output logic                     sum_last
);
   import bfd_pkg::*;

   localparam int MW = 3 * SUM_W;

   logic [MW-1:0]      mem [0:DEPTH-1];
   logic [MW-1:0]      rd_data_ff;
   logic               s1_valid_ff;
   bfd_ctl_type        s1_ctl_ff;
   logic [AW-1:0]      s1_addr_ff;
   logic [3*PIX_W-1:0] s1_pix_ff;
   logic               fwd_valid_ff;
   logic [AW-1:0]      fwd_addr_ff;
   logic [MW-1:0]      fwd_data_ff;
   logic [MW-1:0]      base;
   logic [MW-1:0]      new_sum;
   logic               wr_en;

   // Pick the stored or forwarded sum and add the pixel
   always_comb begin
      if (fwd_valid_ff && fwd_addr_ff == s1_addr_ff) begin
         base = fwd_data_ff;
      end else begin
         base = rd_data_ff;
      end
      for (int c = 0; c < 3; c++) begin
         if (s1_ctl_ff.first) begin
            new_sum[c*SUM_W +: SUM_W] = SUM_W'(s1_pix_ff[c*PIX_W +: PIX_W]);
         end else begin
            new_sum[c*SUM_W +: SUM_W] = base[c*SUM_W +: SUM_W]
                                      + SUM_W'(s1_pix_ff[c*PIX_W +: PIX_W]);
         end
      end
      wr_en     = adv && s1_valid_ff && s1_ctl_ff.active;
      sum_valid = s1_valid_ff && s1_ctl_ff.emit;
      sum       = new_sum;
      sum_last  = s1_ctl_ff.last;
   end

   // Memory: read on accept, write back the updated sum
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_data_ff <= mem[addr];
      end
      if (wr_en) begin
         mem[s1_addr_ff] <= new_sum;
      end
   end

   // Hold the item for its update cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ctl_ff  <= ctl;
         s1_addr_ff <= addr;
         s1_pix_ff  <= pix;
      end
   end

   // Keep the last write for forwarding
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else if (wr_en) begin
         fwd_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         fwd_addr_ff <= s1_addr_ff;
         fwd_data_ff <= new_sum;
      end
   end

endmodule

// ===== hdl/bfd_scale.sv =====
// ----------------------------------------------------------------------------
// bfd_scale
// Divides each block sum by factor squared through a multiply by a rounded-up
// reciprocal and a shift, exact for every sum a block can reach, and holds
// the result in the output register.
// ----------------------------------------------------------------------------
module bfd_scale #(
   parameter int SUM_W      = 14,
   parameter int CW         = 4,
   parameter int MAX_FACTOR = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  logic                     in_valid,
   input  logic [3*SUM_W-1:0]       in_sum,
   input  logic                     in_last,
   input  logic [CW-1:0]            s,
   output logic                     rsp_valid,
   output logic [bfd_pkg::PIX_W-1:0] rsp_out_red,
   output logic [bfd_pkg::PIX_W-1:0] rsp_out_green,
   output logic [bfd_pkg::PIX_W-1:0] rsp_out_blue,
   output logic                     rsp_frame_end
);
   import bfd_pkg::*;

   localparam int LOG_F  = $clog2(MAX_FACTOR);
   localparam int SHIFT  = SUM_W + 2 * LOG_F;
   localparam int RW     = SHIFT + 1;
   localparam int PROD_W = SUM_W + RW;

   logic [RW-1:0]      recip [0:MAX_FACTOR];
   logic               s2_valid_ff;
   logic [3*SUM_W-1:0] s2_sum_ff;
   logic               s2_last_ff;
   logic [RW-1:0]      recip_sel;
   logic [PROD_W-1:0]  prod [0:2];
   logic               rsp_valid_ff;
   logic [PIX_W-1:0]   red_ff;
   logic [PIX_W-1:0]   green_ff;
   logic [PIX_W-1:0]   blue_ff;
   logic               frame_end_ff;

   // Reciprocal table, ceil(2^SHIFT / factor^2)
   for (genvar g = 0; g <= MAX_FACTOR; g++) begin : g_recip
      localparam longint unsigned N = (g == 0) ? 64'd1 : 64'(g * g);
      localparam longint unsigned R = ((64'd1 << SHIFT) + N - 64'd1) / N;
      assign recip[g] = RW'(R);
   end

   // Multiply each channel sum
   always_comb begin
      recip_sel = recip[s];
      for (int c = 0; c < 3; c++) begin
         prod[c] = PROD_W'(s2_sum_ff[c*SUM_W +: SUM_W]) * PROD_W'(recip_sel);
      end
   end

   // Sum stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && in_valid) begin
         s2_sum_ff  <= in_sum;
         s2_last_ff <= in_last;
      end
   end

   // Output register: load when empty or taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && s2_valid_ff) begin
         red_ff       <= prod[0][SHIFT +: PIX_W];
         green_ff     <= prod[1][SHIFT +: PIX_W];
         blue_ff      <= prod[2][SHIFT +: PIX_W];
         frame_end_ff <= s2_last_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_red   = red_ff;
   assign rsp_out_green = green_ff;
   assign rsp_out_blue  = blue_ff;
   assign rsp_frame_end = frame_end_ff;

endmodule

// ===== hdl/box_filter_downsampler.sv =====
// ----------------------------------------------------------------------------
// box_filter_downsampler
// Averages each factor-by-factor square of a raster RGB frame into one
// output pixel; one block-column sum memory, read-modify-write per pixel.
//
//   channel  ports                          handshake
//   -------  -----------------------------  -----------------------------
//   req      req_red/green/blue             req_valid, req_stall (out)
//   rsp      rsp_out_red/green/blue,        rsp_valid, rsp_stall (in)
//            rsp_frame_end
//   csr      csr_index, csr_wdata           csr_write
//
// One pixel is taken every clock while req_stall is low; the memory port
// pair (read on accept, write back with forwarding) sets that figure.
// An output pixel is valid once the pixel closing its block has passed the
// sum update, the sum register and the reciprocal multiply into the output.
// req_stall is high while a finished item waits on a stalled rsp side.
// Reset restores factor 1 and a 640 x 480 frame; any register write restarts
// the frame at its top-left pixel. The sum memory is not cleared.
// ----------------------------------------------------------------------------
module box_filter_downsampler #(
   parameter int MAX_WIDTH  = bfd_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bfd_pkg::DEF_MAX_HEIGHT,
   parameter int MAX_FACTOR = bfd_pkg::DEF_MAX_FACTOR
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [bfd_pkg::PIX_W-1:0]       req_red,
   input  logic [bfd_pkg::PIX_W-1:0]       req_green,
   input  logic [bfd_pkg::PIX_W-1:0]       req_blue,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [bfd_pkg::PIX_W-1:0]       rsp_out_red,
   output logic [bfd_pkg::PIX_W-1:0]       rsp_out_green,
   output logic [bfd_pkg::PIX_W-1:0]       rsp_out_blue,
   output logic                            rsp_frame_end,
   input  logic                            csr_write,
   input  logic [bfd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bfd_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import bfd_pkg::*;

   localparam int CW    = $clog2(MAX_FACTOR + 1);
   localparam int LOG_F = $clog2(MAX_FACTOR);
   localparam int SUM_W = PIX_W + 2 * LOG_F;
   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int HW    = $clog2(MAX_HEIGHT + 1);
   localparam int CPW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int RPW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

   logic [FACTOR_W-1:0] factor_ff;
   logic [DIM_W-1:0]    width_ff;
   logic [DIM_W-1:0]    height_ff;
   logic                csr_hit;
   logic                restart;
   logic [CW-1:0]       s_eff;
   logic [WW-1:0]       w_eff;
   logic [HW-1:0]       h_eff;
   logic                adv;
   logic                accept;
   logic [CPW-1:0]      addr;
   bfd_ctl_type         ctl;
   logic                sum_valid;
   logic [3*SUM_W-1:0]  sum;
   logic                sum_last;

   // Decode the register index
   always_comb begin
      unique case (csr_index)
         CSR_FACTOR, CSR_WIDTH, CSR_HEIGHT: csr_hit = 1'b1;
         default:                           csr_hit = 1'b0;
      endcase
      restart = csr_write && csr_hit;
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         factor_ff <= RST_FACTOR;
         width_ff  <= RST_WIDTH;
         height_ff <= RST_HEIGHT;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_FACTOR: factor_ff <= csr_wdata[FACTOR_W-1:0];
            CSR_WIDTH:  width_ff  <= csr_wdata[DIM_W-1:0];
            CSR_HEIGHT: height_ff <= csr_wdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp the registers to their working range
   always_comb begin
      if (factor_ff == '0) begin
         s_eff = CW'(1);
      end else if (32'(factor_ff) > MAX_FACTOR) begin
         s_eff = CW'(MAX_FACTOR);
      end else begin
         s_eff = CW'(factor_ff);
      end
      if (width_ff == '0) begin
         w_eff = WW'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = HW'(1);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         h_eff = HW'(MAX_HEIGHT);
      end else begin
         h_eff = HW'(height_ff);
      end
   end

   // Advance the pipeline unless a result waits on a stalled output
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;
   assign accept    = req_valid && adv;

   bfd_pos #(
      .CPW (CPW),
      .RPW (RPW),
      .WW  (WW),
      .HW  (HW),
      .CW  (CW)
   ) u_pos (
      .clock   (clock),
      .reset   (reset),
      .restart (restart),
      .accept  (accept),
      .s       (s_eff),
      .w       (w_eff),
      .h       (h_eff),
      .addr    (addr),
      .ctl     (ctl)
   );

   bfd_acc #(
      .AW    (CPW),
      .DEPTH (MAX_WIDTH),
      .SUM_W (SUM_W)
   ) u_acc (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .accept    (accept),
      .addr      (addr),
      .ctl       (ctl),
      .pix       ({req_blue, req_green, req_red}),
      .sum_valid (sum_valid),
      .sum       (sum),
      .sum_last  (sum_last)
   );

   bfd_scale #(
      .SUM_W      (SUM_W),
      .CW         (CW),
      .MAX_FACTOR (MAX_FACTOR)
   ) u_scale (
      .clock         (clock),
      .reset         (reset),
      .adv           (adv),
      .in_valid      (sum_valid),
      .in_sum        (sum),
      .in_last       (sum_last),
      .s             (s_eff),
      .rsp_valid     (rsp_valid),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule
